/* rtl/wsd_pkg.sv */
// shared types and constants for the websocket frame deframer
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int LENGTH_BITS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_COUNT = 3'd1;
    localparam logic [2:0] EXT64_COUNT = 3'd7;
    localparam logic [2:0] KEY_COUNT   = 3'd3;

    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       has_data;
        logic       last_in_frame;
    } res_t;

endpackage

/* rtl/wsd_front.sv */
// header parser and payload unmasking, one byte per cycle while push_ready is high
`timescale 1ns / 1ps

module wsd_front
    import wsd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       push_valid,
    input  logic       push_ready,
    output res_t       push_item
);

    phase_t                 phase_reg, phase_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic                   mask_en_reg, mask_en_next;
    logic [2:0]             hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]            key_reg, key_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic [1:0]             key_off_reg, key_off_next;

    logic                   accept;
    logic                   emit;
    logic [LENGTH_BITS-1:0] shifted;
    logic                   spill;
    logic                   sat;
    logic [7:0]             key_byte;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;
    assign shifted  = {len_reg[LENGTH_BITS-9:0], in_byte};
    assign spill    = (len_reg[LENGTH_BITS-1:LENGTH_BITS-8] != 8'd0);
    assign sat      = ovf_reg || spill;

    always_comb
    begin
        unique case (key_off_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        mask_en_next = mask_en_reg;
        hdr_cnt_next = hdr_cnt_reg;
        key_next     = key_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        key_off_next = key_off_reg;
        emit         = 1'b0;
        push_item.payload_byte  = 8'd0;
        push_item.frame_opcode  = opcode_reg;
        push_item.has_data      = 1'b0;
        push_item.last_in_frame = 1'b1;

        unique case (phase_reg)
            PH_HDR1:
            begin
                mask_en_next = in_byte[7];
                ovf_next     = 1'b0;
                len_next     = '0;
                if (in_byte[6:0] == LEN_EXT16)
                begin
                    phase_next   = PH_EXT;
                    hdr_cnt_next = EXT16_COUNT;
                end
                else if (in_byte[6:0] == LEN_EXT64)
                begin
                    phase_next   = PH_EXT;
                    hdr_cnt_next = EXT64_COUNT;
                end
                else
                begin
                    len_next     = LENGTH_BITS'(in_byte[6:0]);
                    key_off_next = 2'd0;
                    key_next     = 32'd0;
                    if (in_byte[7])
                    begin
                        phase_next   = PH_KEY;
                        hdr_cnt_next = KEY_COUNT;
                    end
                    else if (in_byte[6:0] == 7'd0)
                    begin
                        phase_next = PH_HDR0;
                        emit       = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_EXT:
            begin
                if (hdr_cnt_reg != 3'd0)
                begin
                    hdr_cnt_next = hdr_cnt_reg - 3'd1;
                    len_next     = shifted;
                    ovf_next     = sat;
                end
                else
                begin
                    len_next     = sat ? '1 : shifted;
                    key_off_next = 2'd0;
                    key_next     = 32'd0;
                    if (mask_en_reg)
                    begin
                        phase_next   = PH_KEY;
                        hdr_cnt_next = KEY_COUNT;
                    end
                    else if (!sat && (shifted == '0))
                    begin
                        phase_next = PH_HDR0;
                        emit       = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_KEY:
            begin
                key_next = {key_reg[23:0], in_byte};
                if (hdr_cnt_reg != 3'd0)
                begin
                    hdr_cnt_next = hdr_cnt_reg - 3'd1;
                end
                else
                begin
                    key_off_next = 2'd0;
                    if (len_reg == '0)
                    begin
                        phase_next = PH_HDR0;
                        emit       = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                key_off_next            = key_off_reg + 2'd1;
                len_next                = len_reg - LENGTH_BITS'(1);
                emit                    = 1'b1;
                push_item.payload_byte  = in_byte ^ key_byte;
                push_item.has_data      = 1'b1;
                push_item.last_in_frame = (len_reg == LENGTH_BITS'(1));
                if (len_reg == LENGTH_BITS'(1))
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                opcode_next = in_byte[3:0];
                phase_next  = PH_HDR1;
            end
        endcase
    end

    assign push_valid = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            opcode_reg  <= 4'd0;
            mask_en_reg <= 1'b0;
            hdr_cnt_reg <= 3'd0;
            key_reg     <= 32'd0;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            key_off_reg <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            mask_en_reg <= mask_en_next;
            hdr_cnt_reg <= hdr_cnt_next;
            key_reg     <= key_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            key_off_reg <= key_off_next;
        end
    end

`ifndef SYNTH
    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_item.last_in_frame |=> phase_reg == PH_HDR0)
        else $error("frame did not close after its last result");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && !push_item.has_data |-> push_item.last_in_frame)
        else $error("empty frame result not marked last");

    a_no_result_on_opcode: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_HDR0 |-> !push_valid)
        else $error("result produced on first header byte");
`endif

endmodule

/* rtl/wsd_queue.sv */
// small result queue between parser and output stage
`timescale 1ns / 1ps

module wsd_queue
    import wsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  res_t push_item,
    output logic pop_valid,
    input  logic pop_ready,
    output res_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    res_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not follow a push");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("queue count did not follow a pop");
`endif

endmodule

/* rtl/wsd_back.sv */
// output register driving the result stream
`timescale 1ns / 1ps

module wsd_back
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  res_t       pop_item,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic [4:0] m_axis_tuser,
    output logic       m_axis_tlast
);

    logic valid_reg, valid_next;
    res_t item_reg;
    logic load;

    assign load       = !valid_reg || m_axis_tready;
    assign pop_ready  = load;
    assign valid_next = load ? pop_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && pop_valid)
        begin
            item_reg <= pop_item;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = item_reg.payload_byte;
    assign m_axis_tuser  = {item_reg.has_data, item_reg.frame_opcode};
    assign m_axis_tlast  = item_reg.last_in_frame;

endmodule

/* rtl/websocket_frame_deframer.sv */
// websocket frame deframer top level
// usage:
//   s_axis carries the received frame stream, one byte per transaction
//   m_axis carries one transaction per payload byte, unmasked with the key,
//   tagged with the frame opcode in tuser; tlast marks the final one of a frame
//   an empty frame gives a single transaction with has_data low and tlast high
//   header bytes give no output transaction, save at the end of an empty frame
// timing:
//   one input byte per cycle sustained while the queue has room; parser state
//   updates on each accepted byte; a payload byte reaches m_axis by way of the
//   queue and output register (parser into queue, queue into output register)
// reset:
//   queue and output register empty, parser waits for the first header byte
// stall:
//   while m_axis_tready is low the output register holds and the queue fills;
//   s_axis_tready drops once the queue holds QUEUE_DEPTH results, header bytes
//   are then held off as well
`timescale 1ns / 1ps

module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // stream_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // payload_byte
    output logic [4:0] m_axis_tuser,  // frame_opcode, has_data
    output logic       m_axis_tlast
);

    logic push_valid;
    logic push_ready;
    res_t push_item;
    logic pop_valid;
    logic pop_ready;
    res_t pop_item;

    wsd_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    wsd_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    wsd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
